/* hw/rtl/c2d_pkg.sv */
// Shared types and constants of the int8 convolution accumulate unit.
`default_nettype none

package c2d_pkg;

  // Command codes carried by the cmd field of an input item.
  localparam logic [1:0] CMD_WR_ACT  = 2'd0;
  localparam logic [1:0] CMD_WR_WGT  = 2'd1;
  localparam logic [1:0] CMD_COMPUTE = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd0;
  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd1;
  localparam logic [2:0] REG_IN_CHANNELS  = 3'd2;
  localparam logic [2:0] REG_STRIDE_STEP  = 3'd3;
  localparam logic [2:0] REG_PAD_AMOUNT   = 3'd4;
  localparam logic [2:0] REG_KERNEL_3X3   = 3'd5;
  localparam logic [2:0] REG_PAD_VALUE    = 3'd6;

  // Shared multiplier operand widths, bounded by the register and field widths.
  localparam int MUL_A_W = 12;
  localparam int MUL_B_W = 7;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int ACC_W = 25;

  // Signed window coordinate, wide enough for -2 .. 126.
  typedef logic signed [8:0] coord_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_ROWB,
    ST_COLB,
    ST_WBASE,
    ST_TAP0,
    ST_TAP1,
    ST_TAP2,
    ST_MAC,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

/* hw/rtl/c2d_if.sv */
// Channel interfaces of the int8 convolution accumulate unit.
`default_nettype none

interface c2d_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [15:0]       addr;
  logic signed [7:0] data;
  logic [4:0]        out_row;
  logic [4:0]        out_col;
  logic [5:0]        out_ch;

  modport source (output valid, cmd, addr, data, out_row, out_col, out_ch, input ready);
  modport sink (input valid, cmd, addr, data, out_row, out_col, out_ch, output ready);
endinterface

interface c2d_out_if;
  logic               valid;
  logic               ready;
  logic signed [24:0] acc;

  modport source (output valid, acc, input ready);
  modport sink (input valid, acc, output ready);
endinterface

interface c2d_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/int8_conv2d_raw_accumulate_unit.sv */
// Top level of the int8 2-D convolution unit with raw 25-bit accumulator output.
//
// This unit holds an NHWC activation store and an OHWI weight store, both
// filled one signed byte per write transfer, and answers each compute transfer
// with the raw signed sum of activation times weight over a 1x1 or 3x3 window
// and all configured input channels. Write transfers and the unused command
// code leave the unit idle and return nothing. A compute transfer first
// reduces out_ch by MAX_OUT_CH for as long as it is not below MAX_OUT_CH.
// The sweep runs on the single multiply-accumulate path, which consumes one
// activation byte and one weight byte per cycle from the two single-read
// memories; in the tap states before each tap's channel sweep, one shared
// small multiplier forms the tap's activation address.
// The input side is not ready while a compute is in progress. A finished
// result sits in an output register, so the next item is taken while the
// result still waits for its transfer. Configuration is written through its
// own channel, which is always ready, and a written register takes effect in
// the next cycle, so the user must change registers only while no compute is
// in progress and no result is waiting; the unit does not enforce this.
// Stores come up undefined after reset; there is no clearing pass.
`default_nettype none

module int8_conv2d_raw_accumulate_unit #(
  parameter int MAX_HEIGHT = 32,
  parameter int MAX_WIDTH  = 32,
  parameter int MAX_IN_CH  = 64,
  parameter int MAX_OUT_CH = 64
) (
  input wire logic clk,
  input wire logic rst_n,
  c2d_in_if.sink   in_chan,
  c2d_out_if.source out_chan,
  c2d_cfg_if.sink  cfg_chan
);

  import c2d_pkg::*;

  localparam int ACT_DEPTH = MAX_HEIGHT * MAX_WIDTH * MAX_IN_CH;
  localparam int WGT_DEPTH = MAX_OUT_CH * 9 * MAX_IN_CH;
  localparam int ACT_AW    = (ACT_DEPTH > 1) ? $clog2(ACT_DEPTH) : 1;
  localparam int WGT_AW    = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;

  // Configuration registers.
  logic [5:0]        img_h_r, img_h_nxt;
  logic [5:0]        img_w_r, img_w_nxt;
  logic [6:0]        in_chs_r, in_chs_nxt;
  logic [2:0]        stride_r, stride_nxt;
  logic [1:0]        pad_r, pad_nxt;
  logic              k3_r, k3_nxt;
  logic signed [7:0] pad_val_r, pad_val_nxt;

  // Saturated register values as they are used by the computation.
  logic [5:0] h_eff;
  logic [5:0] w_eff;
  logic [6:0] c_eff;
  logic [2:0] s_eff;
  logic [1:0] p_eff;

  state_t state_r, state_nxt;

  logic [4:0]  orow_r, orow_nxt;
  logic [4:0]  ocol_r, ocol_nxt;
  logic [5:0]  och_r, och_nxt;
  coord_t      row0_r, row0_nxt;
  coord_t      col0_r, col0_nxt;
  logic [1:0]  kh_r, kh_nxt;
  logic [1:0]  kw_r, kw_nxt;
  coord_t      ih_r, ih_nxt;
  coord_t      iw_r, iw_nxt;
  logic        inside_r, inside_nxt;
  logic [MUL_A_W-1:0] prow_r, prow_nxt;
  logic [ACT_AW-1:0]  aadr_r, aadr_nxt;
  logic [WGT_AW-1:0]  wadr_r, wadr_nxt;
  logic [6:0]  ic_r, ic_nxt;

  // Multiply-accumulate pipeline: memory read, product, accumulate.
  logic               p1_vld_r, p1_vld_nxt;
  logic               p1_pad_r, p1_pad_nxt;
  logic               p2_vld_r, p2_vld_nxt;
  logic signed [15:0] prod_r, prod_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [ACC_W-1:0]   out_acc_r, out_acc_nxt;

  // Shared address multiplier.
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;

  logic in_ready;
  logic in_xfer;
  logic out_free;
  logic och_over;
  logic ic_last;
  logic tap_last;
  logic act_we;
  logic wgt_we;
  logic [7:0] act_q;
  logic [7:0] wgt_q;
  logic signed [15:0] a_ext;
  logic signed [15:0] w_ext;

  // Effective configuration, saturated into the legal ranges.
  always_comb begin
    if (img_h_r == 6'd0) begin
      h_eff = 6'd1;
    end else if (32'(img_h_r) > MAX_HEIGHT) begin
      h_eff = 6'(MAX_HEIGHT);
    end else begin
      h_eff = img_h_r;
    end
    if (img_w_r == 6'd0) begin
      w_eff = 6'd1;
    end else if (32'(img_w_r) > MAX_WIDTH) begin
      w_eff = 6'(MAX_WIDTH);
    end else begin
      w_eff = img_w_r;
    end
    if (in_chs_r == 7'd0) begin
      c_eff = 7'd1;
    end else if (32'(in_chs_r) > MAX_IN_CH) begin
      c_eff = 7'(MAX_IN_CH);
    end else begin
      c_eff = in_chs_r;
    end
    if (stride_r == 3'd0) begin
      s_eff = 3'd1;
    end else if (stride_r > 3'd4) begin
      s_eff = 3'd4;
    end else begin
      s_eff = stride_r;
    end
    p_eff = (pad_r == 2'd3) ? 2'd2 : pad_r;
  end

  assign in_xfer  = in_chan.valid && in_ready;
  assign out_free = !out_valid_r || out_chan.ready;
  assign och_over = 32'(och_r) >= MAX_OUT_CH;
  assign ic_last  = ic_r == (c_eff - 7'd1);
  assign tap_last = !k3_r || (kh_r == 2'd2 && kw_r == 2'd2);

  assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer && in_chan.cmd == CMD_COMPUTE) begin
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        if (!och_over) begin
          state_nxt = ST_ROWB;
        end
      end
      ST_ROWB:  state_nxt = ST_COLB;
      ST_COLB:  state_nxt = ST_WBASE;
      ST_WBASE: state_nxt = ST_TAP0;
      ST_TAP0:  state_nxt = ST_TAP1;
      ST_TAP1:  state_nxt = ST_TAP2;
      ST_TAP2:  state_nxt = ST_MAC;
      ST_MAC: begin
        if (ic_last) begin
          state_nxt = tap_last ? ST_DRAIN : ST_TAP0;
        end
      end
      ST_DRAIN: begin
        if (!p1_vld_r && !p2_vld_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs: handshake and the operands of the shared multiplier.
  always_comb begin
    in_ready = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_ROWB: begin
        mul_a = MUL_A_W'(orow_r);
        mul_b = MUL_B_W'(s_eff);
      end
      ST_COLB: begin
        mul_a = MUL_A_W'(ocol_r);
        mul_b = MUL_B_W'(s_eff);
      end
      ST_WBASE: begin
        // Filter index is och*9 for a 3x3 kernel, och for a 1x1 kernel.
        mul_a = k3_r ? (MUL_A_W'({och_r, 3'b000}) + MUL_A_W'(och_r)) : MUL_A_W'(och_r);
        mul_b = c_eff;
      end
      ST_TAP1: begin
        mul_a = MUL_A_W'(ih_r[5:0]);
        mul_b = MUL_B_W'(w_eff);
      end
      ST_TAP2: begin
        mul_a = prow_r + MUL_A_W'(iw_r[5:0]);
        mul_b = c_eff;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign in_chan.ready  = in_ready;
  assign cfg_chan.ready = 1'b1;

  // Store writes take effect at the transfer edge; out-of-range writes drop.
  assign act_we = in_xfer && in_chan.cmd == CMD_WR_ACT && 32'(in_chan.addr) < ACT_DEPTH;
  assign wgt_we = in_xfer && in_chan.cmd == CMD_WR_WGT && 32'(in_chan.addr) < WGT_DEPTH;

  c2d_ram #(.WIDTH(8), .DEPTH(ACT_DEPTH)) u_act_ram (
    .clk   (clk),
    .we    (act_we),
    .waddr (ACT_AW'(in_chan.addr)),
    .wdata (in_chan.data),
    .raddr (aadr_r),
    .rdata (act_q)
  );

  c2d_ram #(.WIDTH(8), .DEPTH(WGT_DEPTH)) u_wgt_ram (
    .clk   (clk),
    .we    (wgt_we),
    .waddr (WGT_AW'(in_chan.addr)),
    .wdata (in_chan.data),
    .raddr (wadr_r),
    .rdata (wgt_q)
  );

  // Taps outside the image take the pad value instead of the stored byte.
  assign a_ext = p1_pad_r ? 16'(pad_val_r) : 16'($signed(act_q));
  assign w_ext = 16'($signed(wgt_q));

  // Datapath next values.
  always_comb begin
    img_h_nxt   = img_h_r;
    img_w_nxt   = img_w_r;
    in_chs_nxt  = in_chs_r;
    stride_nxt  = stride_r;
    pad_nxt     = pad_r;
    k3_nxt      = k3_r;
    pad_val_nxt = pad_val_r;
    if (cfg_chan.valid) begin
      case (cfg_chan.index)
        REG_IMAGE_HEIGHT: img_h_nxt   = cfg_chan.data[5:0];
        REG_IMAGE_WIDTH:  img_w_nxt   = cfg_chan.data[5:0];
        REG_IN_CHANNELS:  in_chs_nxt  = cfg_chan.data[6:0];
        REG_STRIDE_STEP:  stride_nxt  = cfg_chan.data[2:0];
        REG_PAD_AMOUNT:   pad_nxt     = cfg_chan.data[1:0];
        REG_KERNEL_3X3:   k3_nxt      = cfg_chan.data[0];
        REG_PAD_VALUE:    pad_val_nxt = $signed(cfg_chan.data);
        default: begin
          img_h_nxt = img_h_r;
        end
      endcase
    end

    orow_nxt   = orow_r;
    ocol_nxt   = ocol_r;
    och_nxt    = och_r;
    row0_nxt   = row0_r;
    col0_nxt   = col0_r;
    kh_nxt     = kh_r;
    kw_nxt     = kw_r;
    ih_nxt     = ih_r;
    iw_nxt     = iw_r;
    inside_nxt = inside_r;
    prow_nxt   = prow_r;
    aadr_nxt   = aadr_r;
    wadr_nxt   = wadr_r;
    ic_nxt     = ic_r;
    p1_vld_nxt = 1'b0;
    p1_pad_nxt = p1_pad_r;
    acc_nxt    = acc_r;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          orow_nxt = in_chan.out_row;
          ocol_nxt = in_chan.out_col;
          och_nxt  = in_chan.out_ch;
          acc_nxt  = '0;
        end
      end
      ST_MOD: begin
        if (och_over) begin
          och_nxt = och_r - 6'(MAX_OUT_CH);
        end
      end
      ST_ROWB: row0_nxt = coord_t'(mul_p[6:0]) - coord_t'(p_eff);
      ST_COLB: col0_nxt = coord_t'(mul_p[6:0]) - coord_t'(p_eff);
      ST_WBASE: begin
        wadr_nxt = WGT_AW'(mul_p);
        kh_nxt   = 2'd0;
        kw_nxt   = 2'd0;
      end
      ST_TAP0: begin
        ih_nxt     = row0_r + coord_t'(kh_r);
        iw_nxt     = col0_r + coord_t'(kw_r);
        inside_nxt = !ih_nxt[8] && (ih_nxt[7:0] < 8'(h_eff)) &&
                     !iw_nxt[8] && (iw_nxt[7:0] < 8'(w_eff));
      end
      ST_TAP1: prow_nxt = mul_p[MUL_A_W-1:0];
      ST_TAP2: begin
        aadr_nxt = ACT_AW'(mul_p);
        ic_nxt   = 7'd0;
      end
      ST_MAC: begin
        p1_vld_nxt = 1'b1;
        p1_pad_nxt = !inside_r;
        aadr_nxt   = aadr_r + ACT_AW'(1);
        wadr_nxt   = wadr_r + WGT_AW'(1);
        ic_nxt     = ic_r + 7'd1;
        if (ic_last && !tap_last) begin
          if (kw_r == 2'd2) begin
            kw_nxt = 2'd0;
            kh_nxt = kh_r + 2'd1;
          end else begin
            kw_nxt = kw_r + 2'd1;
          end
        end
      end
      default: begin
        p1_vld_nxt = 1'b0;
      end
    endcase

    p2_vld_nxt = p1_vld_r;
    prod_nxt   = a_ext * w_ext;
    if (p2_vld_r) begin
      acc_nxt = acc_r + {{(ACC_W - 16){prod_r[15]}}, prod_r};
    end

    out_valid_nxt = out_valid_r;
    out_acc_nxt   = out_acc_r;
    if (state_r == ST_DONE && out_free) begin
      out_valid_nxt = 1'b1;
      out_acc_nxt   = acc_r;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.acc   = $signed(out_acc_r);

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      p1_vld_r    <= 1'b0;
      p2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      img_h_r     <= 6'd32;
      img_w_r     <= 6'd32;
      in_chs_r    <= 7'd64;
      stride_r    <= 3'd1;
      pad_r       <= 2'd0;
      k3_r        <= 1'b0;
      pad_val_r   <= 8'sd0;
    end else begin
      state_r     <= state_nxt;
      p1_vld_r    <= p1_vld_nxt;
      p2_vld_r    <= p2_vld_nxt;
      out_valid_r <= out_valid_nxt;
      img_h_r     <= img_h_nxt;
      img_w_r     <= img_w_nxt;
      in_chs_r    <= in_chs_nxt;
      stride_r    <= stride_nxt;
      pad_r       <= pad_nxt;
      k3_r        <= k3_nxt;
      pad_val_r   <= pad_val_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    orow_r    <= orow_nxt;
    ocol_r    <= ocol_nxt;
    och_r     <= och_nxt;
    row0_r    <= row0_nxt;
    col0_r    <= col0_nxt;
    kh_r      <= kh_nxt;
    kw_r      <= kw_nxt;
    ih_r      <= ih_nxt;
    iw_r      <= iw_nxt;
    inside_r  <= inside_nxt;
    prow_r    <= prow_nxt;
    aadr_r    <= aadr_nxt;
    wadr_r    <= wadr_nxt;
    ic_r      <= ic_nxt;
    p1_pad_r  <= p1_pad_nxt;
    prod_r    <= prod_nxt;
    acc_r     <= acc_nxt;
    out_acc_r <= out_acc_nxt;
  end

`ifndef SYNTH
  // A memory read is only in flight as a result of the channel sweep state.
  a_read_from_mac: assert property (@(posedge clk) disable iff (!rst_n)
    p1_vld_r |-> $past(state_r == ST_MAC))
    else $error("read pipeline valid without a preceding sweep cycle");

  // The result is only taken once the accumulate pipeline has emptied.
  a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> (!p1_vld_r && !p2_vld_r))
    else $error("result loaded while products are still in flight");

  // A new result appears only from the completion state.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result valid raised outside completion");

  // Activation reads of in-image taps stay inside the store.
  a_act_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MAC && inside_r) |-> (32'(aadr_r) < ACT_DEPTH))
    else $error("activation read beyond the store");

  // Weight reads stay inside the store.
  a_wgt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MAC) |-> (32'(wadr_r) < WGT_DEPTH))
    else $error("weight read beyond the store");
`endif

endmodule

`default_nettype wire

/* hw/rtl/c2d_ram.sv */
// Generic single-write, single-read memory with registered read data.
`default_nettype none

module c2d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
